@@ hdl/hsbc_pkg.sv @@
`default_nettype none
package hsbc_pkg;

  localparam int unsigned FRAME_BITS = 22;
  localparam int unsigned CHIP_BITS  = 2 * FRAME_BITS;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  localparam logic [1:0] STAT_CLEAN     = 2'd0;
  localparam logic [1:0] STAT_CORRECTED = 2'd1;
  localparam logic [1:0] STAT_DOUBLE    = 2'd2;

  localparam logic [15:0] LO_BYTE_MASK = 16'h00ff;
  localparam logic [15:0] HI_BYTE_MASK = 16'hff00;
  localparam logic [3:0]  NIB_MASK     = 4'hf;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic [15:0] error_mask;
    logic [15:0] received_word;
  } req_t;

  typedef struct packed {
    logic [15:0]          code_word;
    logic [CHIP_BITS-1:0] chip_frame;
    logic [7:0]           decoded_byte;
    logic [1:0]           decode_status;
  } res_t;

  typedef struct packed {
    logic [3:0] nib;
    logic [1:0] status;
  } nib_dec_t;

  // code byte, bit 0 up: p0 h0 h1 h2 d0 d1 d2 d3
  function automatic logic [7:0] nibble_encode(input logic [3:0] n);
    logic [7:0] body;
    begin
      body[0] = 1'b0;
      body[1] = n[0] ^ n[1] ^ n[2];
      body[2] = n[0] ^ n[1] ^ n[3];
      body[3] = n[0] ^ n[2] ^ n[3];
      body[7:4] = n;
      body[0] = ^body;
      return body;
    end
  endfunction

  function automatic nib_dec_t byte_decode(input logic [7:0] b);
    logic [2:0] syn;
    logic       overall;
    logic [3:0] d;
    nib_dec_t   r;
    begin
      d = b[7:4];
      overall = ^b;
      syn[0] = b[4] ^ b[5] ^ b[6] ^ b[1];
      syn[1] = b[4] ^ b[5] ^ b[7] ^ b[2];
      syn[2] = b[4] ^ b[6] ^ b[7] ^ b[3];
      unique case (syn)
        3'd3: d[1] = ~d[1];
        3'd5: d[2] = ~d[2];
        3'd6: d[3] = ~d[3];
        3'd7: d[0] = ~d[0];
        default: d = d;
      endcase
      if ((syn != 3'd0) && !overall) begin
        r.nib = 4'd0;
        r.status = STAT_DOUBLE;
      end else begin
        r.nib = d & NIB_MASK;
        r.status = ((syn != 3'd0) || overall) ? STAT_CORRECTED : STAT_CLEAN;
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/hsbc_core.sv @@
`default_nettype none
module hsbc_core (
  input  wire hsbc_pkg::req_t req,
  output hsbc_pkg::res_t      res
);

  logic [15:0]                         word;
  logic [hsbc_pkg::FRAME_BITS-1:0]     frame;
  logic [hsbc_pkg::CHIP_BITS-1:0]      chips;
  hsbc_pkg::nib_dec_t                  dec_lo;
  hsbc_pkg::nib_dec_t                  dec_hi;
  logic [15:0]                         rw_lo;
  logic [15:0]                         rw_hi;

  always_comb begin
    word = {hsbc_pkg::nibble_encode(req.data_byte[3:0]),
            hsbc_pkg::nibble_encode(req.data_byte[7:4])} ^ req.error_mask;
    // start 1,1 / code byte / stop 0, twice
    frame = {1'b0, word[15:8], 2'b11, 1'b0, word[7:0], 2'b11};
    for (int k = 0; k < hsbc_pkg::FRAME_BITS; k++) begin
      chips[2*k]   = ~frame[k];
      chips[2*k+1] = frame[k];
    end
  end

  assign rw_lo  = req.received_word & hsbc_pkg::LO_BYTE_MASK;
  assign rw_hi  = req.received_word & hsbc_pkg::HI_BYTE_MASK;
  assign dec_lo = hsbc_pkg::byte_decode(rw_lo[7:0]);
  assign dec_hi = hsbc_pkg::byte_decode(rw_hi[15:8]);

  always_comb begin
    res = '0;
    if (req.req_type == hsbc_pkg::REQ_ENCODE) begin
      res.code_word  = word;
      res.chip_frame = chips;
    end else if ((dec_lo.status == hsbc_pkg::STAT_DOUBLE) ||
                 (dec_hi.status == hsbc_pkg::STAT_DOUBLE)) begin
      res.decode_status = hsbc_pkg::STAT_DOUBLE;
    end else begin
      res.decoded_byte  = {dec_lo.nib, dec_hi.nib};
      res.decode_status = ((dec_lo.status != hsbc_pkg::STAT_CLEAN) ||
                           (dec_hi.status != hsbc_pkg::STAT_CLEAN)) ?
                          hsbc_pkg::STAT_CORRECTED : hsbc_pkg::STAT_CLEAN;
    end
  end

endmodule
`default_nettype wire

@@ hdl/hamming_secded_byte_codec.sv @@
`default_nettype none
// Each beat is taken into the input reg; its result then goes into the result reg.
// Throughput: one beat per cycle unless out_ready stalls; single-pass XOR between the regs.
// out_valid may sit stalled while one more beat is taken into the input register.
// Reset (rst_n low, synchronous) clears both valid flags; payload registers are not reset.
module hamming_secded_byte_codec (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           in_req_type,
  input  wire  [7:0]                    in_data_byte,
  input  wire  [15:0]                   in_error_mask,
  input  wire  [15:0]                   in_received_word,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [15:0]                   out_code_word,
  output logic [hsbc_pkg::CHIP_BITS-1:0] out_chip_frame,
  output logic [7:0]                    out_decoded_byte,
  output logic [1:0]                    out_decode_status
);

  hsbc_pkg::req_t req_r;
  hsbc_pkg::res_t res_r;
  hsbc_pkg::res_t res_nxt;
  logic           req_vld_r;
  logic           res_vld_r;
  logic           res_load;

  assign res_load = !res_vld_r || out_ready;
  assign in_ready = !req_vld_r || res_load;

  hsbc_core u_core (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_vld_r <= in_valid;
      end
      if (res_load) begin
        res_vld_r <= req_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.req_type      <= in_req_type;
      req_r.data_byte     <= in_data_byte;
      req_r.error_mask    <= in_error_mask;
      req_r.received_word <= in_received_word;
    end
    if (res_load && req_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_code_word     = res_r.code_word;
  assign out_chip_frame    = res_r.chip_frame;
  assign out_decoded_byte  = res_r.decoded_byte;
  assign out_decode_status = res_r.decode_status;

endmodule
`default_nettype wire
